/* hdl/priority_scheduler_with_aging_core_defines.svh */
// Assertion macros for the scheduler core
`ifndef PRIORITY_SCHEDULER_WITH_AGING_CORE_DEFINES_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/psa_pkg.sv */
`default_nettype none
package psa_pkg;
    typedef enum logic [1:0] {
        REG_PREEMPT = 2'd0,
        REG_AGING_EN = 2'd1,
        REG_AGING_PERIOD = 2'd2,
        REG_AGING_STEP = 2'd3
    } reg_index_t;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  task_id;
        logic [7:0]  base_prio;
        logic [15:0] burst_length;
    } req_t;

    typedef struct packed {
        logic        rejected;
        logic        busy_res;
        logic [7:0]  running_id;
        logic        finished;
        logic [31:0] first_dispatch;
        logic [31:0] done_time;
        logic [31:0] wait_time;
        logic [31:0] turnaround;
        logic [31:0] now;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] prio;
        logic [31:0] arrival;
        logic [15:0] remaining;
        logic        started;
        logic [31:0] first_run;
        logic [31:0] enq_time;
        logic [31:0] wait_sum;
    } task_t;

    // true when a ranks strictly above b
    function automatic logic ranks_above(input task_t a, input task_t b);
        logic r;
        if (a.prio != b.prio)
        begin
            r = a.prio > b.prio;
        end
        else if (a.arrival != b.arrival)
        begin
            r = a.arrival < b.arrival;
        end
        else
        begin
            r = a.id < b.id;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* hdl/priority_scheduler_with_aging_core.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | psa_pkg::req_t
// out     | output    | out_valid/out_ready | psa_pkg::rsp_t
// cfg     | input     | cfg_we              | cfg_index, cfg_data
// Arrive: the request is written to the queue at acceptance; the input is free again once its result is loaded.
// Tick: a restoring divider forms now mod period, then the queue is aged if aging is due,
// ranked and the top entry swapped in; with the queue empty the ranking is skipped.
// A single slot read/compare unit walks the queue memory once to age (when due), once to rank.
// Reset clears control only; the queue memory needs no clearing.
// A result waits in the output register while the next request enters;
// a second result holds the sequencer until the first is taken.
`default_nettype none
`include "priority_scheduler_with_aging_core_defines.svh"
module priority_scheduler_with_aging_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire psa_pkg::req_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output psa_pkg::rsp_t      out_data,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);
    import psa_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_AGE_RD, S_AGE_WR, S_SCAN_RD, S_SCAN_CMP,
        S_LAST_RD, S_LAST_WAIT, S_SWAP, S_RUN, S_OUT
    } state_t;

    state_t state_reg;
    logic preempt_reg, aging_en_reg;
    logic [15:0] period_reg;
    logic [7:0] step_reg;
    logic [31:0] now_reg;
    logic [CW-1:0] count_reg;
    logic run_valid_reg;
    task_t run_reg;
    rsp_t out_reg;
    rsp_t out_hold_reg;
    logic out_valid_reg;
    logic out_load;

    logic [31:0] div_rem_reg;
    logic [31:0] div_q_reg;
    logic [5:0] div_cnt_reg;
    logic aging_due_reg;

    logic [CW-1:0] idx_reg;
    logic [AW-1:0] best_reg;
    task_t best_task_reg;
    logic have_best_reg;
    task_t last_reg;

    task_t mem [QUEUE_DEPTH];
    task_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic rd_en;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    task_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    logic [32:0] div_trial;
    logic [16:0] aged;
    task_t cand;
    logic cand_ok;
    logic [31:0] fin;
    task_t started_best;
    rsp_t idle_rsp;
    rsp_t run_rsp;

    assign div_trial = {div_rem_reg[31:0], div_q_reg[31]} - {17'd0, period_reg};
    assign aged = {1'b0, rd_data_reg.prio} + {9'd0, step_reg};
    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data = out_hold_reg;

    always_comb
    begin
        started_best = best_task_reg;
        if (!best_task_reg.started)
        begin
            started_best.started = 1'b1;
            started_best.first_run = now_reg;
        end
        started_best.wait_sum = best_task_reg.wait_sum + (now_reg - best_task_reg.enq_time);
        cand_ok = !have_best_reg || ranks_above(rd_data_reg, best_task_reg);
        fin = now_reg + 32'd1;
        cand = rd_data_reg;
        idle_rsp = '0;
        idle_rsp.now = now_reg;
        idle_rsp.rejected = (in_data.opcode == OP_ARRIVE)
                            && (count_reg == CW'(QUEUE_DEPTH));
        run_rsp = out_reg;
        if (run_valid_reg)
        begin
            run_rsp.busy_res = 1'b1;
            run_rsp.running_id = run_reg.id;
            if (run_reg.remaining == 16'd1)
            begin
                run_rsp.finished = 1'b1;
                run_rsp.first_dispatch = run_reg.first_run;
                run_rsp.done_time = fin;
                run_rsp.wait_time = run_reg.wait_sum;
                run_rsp.turnaround = fin - run_reg.arrival;
            end
        end
    end

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        wr_en = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = rd_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                wr_data.id = in_data.task_id;
                wr_data.prio = {8'd0, in_data.base_prio};
                wr_data.arrival = now_reg;
                wr_data.remaining = (in_data.burst_length == 16'd0) ? 16'd1
                                                                     : in_data.burst_length;
                wr_data.started = 1'b0;
                wr_data.first_run = 32'd0;
                wr_data.enq_time = now_reg;
                wr_data.wait_sum = 32'd0;
                wr_en = in_valid && in_data.opcode == OP_ARRIVE
                        && count_reg != CW'(QUEUE_DEPTH);
            end
            S_AGE_RD, S_SCAN_RD:
            begin
                rd_en = 1'b1;
            end
            S_AGE_WR:
            begin
                wr_en = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data.prio = aged[16] ? 16'hFFFF : aged[15:0];
            end
            S_LAST_RD:
            begin
                rd_en = 1'b1;
                rd_addr = AW'(count_reg - CW'(1));
            end
            S_SWAP:
            begin
                wr_addr = best_reg;
                if (!run_valid_reg)
                begin
                    wr_en = 1'b1;
                    wr_data = last_reg;
                end
                else if (preempt_reg && ranks_above(best_task_reg, run_reg))
                begin
                    wr_en = 1'b1;
                    wr_data = run_reg;
                    wr_data.enq_time = now_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            preempt_reg <= 1'b0;
            aging_en_reg <= 1'b0;
            period_reg <= 16'd0;
            step_reg <= 8'd1;
            now_reg <= 32'd0;
            count_reg <= '0;
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_PREEMPT: preempt_reg <= cfg_data[0];
                    REG_AGING_EN: aging_en_reg <= cfg_data[0];
                    REG_AGING_PERIOD: period_reg <= cfg_data;
                    REG_AGING_STEP: step_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_hold_reg <= out_reg;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        out_reg <= idle_rsp;
                        if (in_data.opcode == OP_ARRIVE)
                        begin
                            if (count_reg != CW'(QUEUE_DEPTH))
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            div_rem_reg <= 32'd0;
                            div_q_reg <= now_reg;
                            div_cnt_reg <= 6'd0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    // restoring division: one quotient bit a cycle
                    if (!div_trial[32])
                    begin
                        div_rem_reg <= div_trial[31:0];
                    end
                    else
                    begin
                        div_rem_reg <= {div_rem_reg[30:0], div_q_reg[31]};
                    end
                    div_q_reg <= {div_q_reg[30:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd31)
                    begin
                        aging_due_reg <= aging_en_reg && period_reg != 16'd0
                                         && now_reg != 32'd0
                                         && (!div_trial[32] ? div_trial[31:0]
                                             : {div_rem_reg[30:0], div_q_reg[31]}) == 32'd0;
                        idx_reg <= '0;
                        state_reg <= S_AGE_RD;
                    end
                end
                S_AGE_RD:
                begin
                    if (idx_reg == count_reg || !aging_due_reg)
                    begin
                        idx_reg <= '0;
                        have_best_reg <= 1'b0;
                        state_reg <= (count_reg == '0) ? S_RUN : S_SCAN_RD;
                    end
                    else
                    begin
                        state_reg <= S_AGE_WR;
                    end
                end
                S_AGE_WR:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    state_reg <= S_AGE_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (cand_ok)
                    begin
                        best_task_reg <= cand;
                        best_reg <= idx_reg[AW-1:0];
                        have_best_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + CW'(1);
                    state_reg <= (idx_reg + CW'(1) == count_reg) ? S_LAST_RD : S_SCAN_RD;
                end
                S_LAST_RD:
                begin
                    state_reg <= S_LAST_WAIT;
                end
                S_LAST_WAIT:
                begin
                    last_reg <= rd_data_reg;
                    state_reg <= S_SWAP;
                end
                S_SWAP:
                begin
                    if (!run_valid_reg)
                    begin
                        run_reg <= started_best;
                        run_valid_reg <= 1'b1;
                        count_reg <= count_reg - CW'(1);
                    end
                    else if (preempt_reg && ranks_above(best_task_reg, run_reg))
                    begin
                        run_reg <= started_best;
                    end
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    out_reg <= run_rsp;
                    if (run_valid_reg)
                    begin
                        run_reg.remaining <= run_reg.remaining - 16'd1;
                        if (run_reg.remaining == 16'd1)
                        begin
                            run_valid_reg <= 1'b0;
                        end
                    end
                    now_reg <= fin;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PSA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `PSA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid_reg && !out_ready,
                     out_valid_reg && $stable(out_hold_reg))
    `PSA_ASSERT_NEXT(a_out_after, clk, rst_n, state_reg == S_OUT, out_valid_reg)
    `PSA_ASSERT_IMP(a_finish_idle, clk, rst_n, out_valid_reg && out_hold_reg.finished,
                    out_hold_reg.busy_res)
endmodule
`default_nettype wire

/* bench/priority_scheduler_with_aging_core_test.sv */
`timescale 1ns / 1ps
module priority_scheduler_with_aging_core_test;
    import psa_pkg::*;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready = 1'b0;
    rsp_t out_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    priority_scheduler_with_aging_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    typedef struct {
        logic [7:0] id;
        logic [15:0] prio;
        logic [31:0] arrival;
        logic [15:0] remaining;
        logic started;
        logic [31:0] first_run;
        logic [31:0] enq_time;
        logic [31:0] wait_sum;
    } job_t;

    logic sched_preempt;
    logic sched_aging_en;
    logic [15:0] sched_period;
    logic [7:0] sched_step;
    logic [31:0] sched_now;
    int waiting_count;
    job_t waiting_jobs[DEPTH];
    logic job_running;
    job_t current_job;

    rsp_t pending_rsp[$];
    int errors = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    int hold_req = 0;
    int hold_seen = 0;
    logic drain_done;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic outranks(job_t a, job_t b);
        if (a.prio != b.prio)
        begin
            return a.prio > b.prio;
        end
        if (a.arrival != b.arrival)
        begin
            return a.arrival < b.arrival;
        end
        return a.id < b.id;
    endfunction

    function automatic int top_slot();
        int b;
        b = 0;
        for (int i = 1; i < waiting_count; i++)
        begin
            if (outranks(waiting_jobs[i], waiting_jobs[b]))
            begin
                b = i;
            end
        end
        return b;
    endfunction

    function automatic void begin_job();
        if (!current_job.started)
        begin
            current_job.started = 1'b1;
            current_job.first_run = sched_now;
        end
        current_job.wait_sum = current_job.wait_sum + (sched_now - current_job.enq_time);
    endfunction

    function automatic rsp_t schedule(req_t r);
        rsp_t o;
        int b;
        logic [16:0] p;
        job_t c;
        logic [31:0] fin;
        o = '0;
        o.now = sched_now;
        if (r.opcode == OP_ARRIVE)
        begin
            if (waiting_count >= DEPTH)
            begin
                o.rejected = 1'b1;
                return o;
            end
            c.id = r.task_id;
            c.prio = {8'd0, r.base_prio};
            c.arrival = sched_now;
            c.remaining = (r.burst_length == 16'd0) ? 16'd1 : r.burst_length;
            c.started = 1'b0;
            c.first_run = '0;
            c.enq_time = sched_now;
            c.wait_sum = '0;
            waiting_jobs[waiting_count] = c;
            waiting_count++;
            return o;
        end
        if (sched_aging_en && sched_period != 0 && sched_now != 0
            && sched_now % sched_period == 0)
        begin
            for (int i = 0; i < waiting_count; i++)
            begin
                p = waiting_jobs[i].prio + sched_step;
                waiting_jobs[i].prio = p[16] ? 16'hFFFF : p[15:0];
            end
        end
        if (!job_running)
        begin
            if (waiting_count > 0)
            begin
                b = top_slot();
                current_job = waiting_jobs[b];
                waiting_count--;
                waiting_jobs[b] = waiting_jobs[waiting_count];
                job_running = 1'b1;
                begin_job();
            end
        end
        else if (sched_preempt && waiting_count > 0)
        begin
            b = top_slot();
            if (outranks(waiting_jobs[b], current_job))
            begin
                c = waiting_jobs[b];
                waiting_jobs[b] = current_job;
                waiting_jobs[b].enq_time = sched_now;
                current_job = c;
                begin_job();
            end
        end
        if (job_running)
        begin
            o.busy_res = 1'b1;
            o.running_id = current_job.id;
            current_job.remaining = current_job.remaining - 16'd1;
            if (current_job.remaining == 0)
            begin
                fin = sched_now + 32'd1;
                o.finished = 1'b1;
                o.first_dispatch = current_job.first_run;
                o.done_time = fin;
                o.wait_time = current_job.wait_sum;
                o.turnaround = fin - current_job.arrival;
                job_running = 1'b0;
            end
        end
        sched_now++;
        return o;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
        begin
            return 0;
        end
        if (k < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(req_t r);
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_rsp.push_back(schedule(r));
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_with_gap(req_t r);
        int g;
        g = gap_len();
        repeat (g) @(posedge clk);
        send_request(r);
    endtask

    function automatic req_t arrival(logic [7:0] id, logic [7:0] pr, logic [15:0] bl);
        req_t r;
        r.opcode = OP_ARRIVE;
        r.task_id = id;
        r.base_prio = pr;
        r.burst_length = bl;
        return r;
    endfunction

    function automatic req_t tick_req();
        req_t r;
        r = req_t'({OP_TICK, $urandom});
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_PREEMPT: sched_preempt = val[0];
            REG_AGING_EN: sched_aging_en = val[0];
            REG_AGING_PERIOD: sched_period = val;
            default: sched_step = val[7:0];
        endcase
    endtask

    task automatic set_config(logic pe, logic ae, logic [15:0] per, logic [7:0] st);
        wait_drained();
        write_reg(REG_PREEMPT, {15'd0, pe});
        write_reg(REG_AGING_EN, {15'd0, ae});
        write_reg(REG_AGING_PERIOD, per);
        write_reg(REG_AGING_STEP, {8'd0, st});
        cfg_we <= 1'b0;
    endtask

    // send ticks until the queue empties, stopping early on a long running burst
    task automatic drain_queue();
        int guard;
        guard = 0;
        while ((job_running || waiting_count > 0) && guard < 4000)
        begin
            if (current_job.remaining > 20 && job_running)
            begin
                break;
            end
            send_with_gap(tick_req());
            guard++;
        end
    endtask

    task automatic test_directed();
        send_request(tick_req());
        send_request(arrival(8'd0, 8'd0, 16'd0));
        send_request(arrival(8'd255, 8'd255, 16'd2));
        send_request(arrival(8'd7, 8'd255, 16'd1));
        send_request(arrival(8'd7, 8'd255, 16'd1));
        send_request(arrival(8'h5a, 8'h5a, 16'hFFFF));
        send_request(arrival(8'ha5, 8'ha5, 16'h8000));
        repeat (8) send_request(tick_req());
        wait_drained();
    endtask

    task automatic test_preempt();
        set_config(1'b1, 1'b0, 16'd0, 8'd1);
        send_request(arrival(8'd1, 8'd10, 16'd3));
        send_request(tick_req());
        send_request(arrival(8'd2, 8'd200, 16'd2));
        send_request(arrival(8'd3, 8'd10, 16'd1));
        repeat (8) send_request(tick_req());
    endtask

    // fill the queue, overflow it, then age it with step 255 and period 1
    task automatic test_full_and_aging();
        set_config(1'b1, 1'b1, 16'd1, 8'd255);
        for (int i = 0; i < DEPTH + 4; i++)
        begin
            send_with_gap(arrival(8'($urandom), 8'($urandom), 16'($urandom_range(1, 3))));
        end
        repeat (300) send_with_gap(tick_req());
        drain_queue();
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_req = hold_req + 1;
        for (int i = 0; i < 40; i++)
        begin
            send_request(($urandom_range(0, 2) == 0) ? tick_req()
                : arrival(8'($urandom), 8'($urandom), 16'($urandom_range(1, 4))));
        end
        wait_drained();
    endtask

    task automatic test_random(int n);
        int sent;
        req_t r;
        logic [15:0] bl;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                set_config(1'($urandom), 1'($urandom),
                    ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 9)),
                    ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
            end
            if (waiting_count < 40 && $urandom_range(0, 99) < 40)
            begin
                case ($urandom_range(0, 9))
                    0: bl = 16'd0;
                    1: bl = 16'($urandom);
                    default: bl = 16'($urandom_range(1, 6));
                endcase
                r = arrival(8'($urandom), 8'($urandom), bl);
            end
            else
            begin
                r = tick_req();
            end
            send_with_gap(r);
            sent++;
            if (job_running && current_job.remaining > 50)
            begin
                // let waiting requests preempt a long burst
                if ($urandom_range(0, 1) == 0)
                begin
                    set_config(1'b1, sched_aging_en, sched_period, sched_step);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    rsp_t e;
                    e = pending_rsp.pop_front();
                    if (e.rejected !== out_data.rejected) begin $error("rejected exp %0h got %0h", e.rejected, out_data.rejected); errors++; end
                    if (e.busy_res !== out_data.busy_res) begin $error("busy_res exp %0h got %0h", e.busy_res, out_data.busy_res); errors++; end
                    if (e.running_id !== out_data.running_id) begin $error("running_id exp %0h got %0h", e.running_id, out_data.running_id); errors++; end
                    if (e.finished !== out_data.finished) begin $error("finished exp %0h got %0h", e.finished, out_data.finished); errors++; end
                    if (e.first_dispatch !== out_data.first_dispatch) begin $error("first_dispatch exp %0h got %0h", e.first_dispatch, out_data.first_dispatch); errors++; end
                    if (e.done_time !== out_data.done_time) begin $error("done_time exp %0h got %0h", e.done_time, out_data.done_time); errors++; end
                    if (e.wait_time !== out_data.wait_time) begin $error("wait_time exp %0h got %0h", e.wait_time, out_data.wait_time); errors++; end
                    if (e.turnaround !== out_data.turnaround) begin $error("turnaround exp %0h got %0h", e.turnaround, out_data.turnaround); errors++; end
                    if (e.now !== out_data.now) begin $error("now exp %0h got %0h", e.now, out_data.now); errors++; end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_off <= 600;
            out_ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if ($urandom_range(0, 99) < 8)
        begin
            out_ready <= 1'b0;
            if ($urandom_range(0, 19) == 0)
            begin
                hold_off <= $urandom_range(10, 40);
            end
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (!in_valid && pending_rsp.size() == 0))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT && !drain_done)
        begin
            $display("priority_scheduler_with_aging_core_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        drain_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_PREEMPT;
        cfg_data = '0;
        sched_preempt = 1'b0;
        sched_aging_en = 1'b0;
        sched_period = '0;
        sched_step = 8'd1;
        sched_now = '0;
        waiting_count = 0;
        job_running = 1'b0;
        current_job = '{default: '0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_preempt();
        test_full_and_aging();
        test_backpressure();
        set_config(1'b0, 1'b1, 16'd3, 8'd2);
        test_random(550);
        set_config(1'b1, 1'b1, 16'd5, 8'd40);
        test_random(550);
        wait_drained();
        drain_done = 1'b1;
        if (errors == 0)
        begin
            $display("priority_scheduler_with_aging_core_test: done, clean");
        end
        else
        begin
            $display("priority_scheduler_with_aging_core_test: done, errors");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/psa_pkg.sv
hdl/priority_scheduler_with_aging_core.sv
bench/priority_scheduler_with_aging_core_test.sv
